// ===== rtl/core/ctfp_pkg.sv =====
`default_nettype none
package ctfp_pkg;
	localparam int unsigned MaxFrame = 90;
	localparam int unsigned TagCount = 11;
	localparam logic [3:0] NoTag = 4'd15;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChBang = 8'h21;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChPlus = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [3:0] TagSa = 4'd6;
	localparam logic [3:0] TagWi = 4'd7;
	localparam logic [3:0] Tag3r = 4'd10;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic crc_ok;
		logic signed [31:0] power_1a;
		logic signed [31:0] power_1b;
		logic signed [31:0] power_2a;
		logic signed [31:0] power_2b;
		logic signed [31:0] power_3a;
		logic signed [31:0] power_3b;
		logic [30:0] sample_count;
		logic rms_mode;
		logic [7:0] reported_wire;
		logic [1:0] wire_pulses;
	} result_t;

	function automatic logic [15:0] tag_code(input logic [3:0] idx);
		logic [15:0] c;
		begin
			case (idx)
				4'd0: c = {8'h31, 8'h41};
				4'd1: c = {8'h31, 8'h42};
				4'd2: c = {8'h32, 8'h41};
				4'd3: c = {8'h32, 8'h42};
				4'd4: c = {8'h33, 8'h41};
				4'd5: c = {8'h33, 8'h42};
				4'd6: c = {8'h53, 8'h41};
				4'd7: c = {8'h57, 8'h49};
				4'd8: c = {8'h31, 8'h52};
				4'd9: c = {8'h32, 8'h52};
				4'd10: c = {8'h33, 8'h52};
				default: c = 16'h0000;
			endcase
			tag_code = c;
		end
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_t b);
		logic [15:0] c;
		begin
			c = crc ^ {8'h00, b};
			for (int i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
			end
			crc_byte = c;
		end
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ctfp_stream_if.sv =====
`default_nettype none
interface ctfp_stream_if #(parameter int unsigned Width = 8);
	logic valid;
	logic ready;
	logic [Width-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ctfp_result_if.sv =====
`default_nettype none
interface ctfp_result_if;
	logic valid;
	logic ready;
	ctfp_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ctfp_result_calc.sv =====
`default_nettype none
module ctfp_result_calc (
	input wire logic [1:0] wire_setting,
	input wire logic ok,
	input wire logic [10:0] found,
	input wire logic [10:0][31:0] vals,
	output ctfp_pkg::result_t res
);
	logic [31:0] sa;
	logic [7:0] wi;
	logic rms;

	always_comb begin
		sa = found[ctfp_pkg::TagSa] ? vals[ctfp_pkg::TagSa] : 32'd0;
		wi = found[ctfp_pkg::TagWi] ? vals[ctfp_pkg::TagWi][7:0] : 8'd0;
		rms = found[ctfp_pkg::Tag3r];
		if (sa[31] || sa == 32'd0) begin
			sa = 32'd1;
		end
		res = '0;
		if (ok) begin
			res.crc_ok = 1'b1;
			res.power_1a = found[8] ? vals[8] : (found[0] ? vals[0] : 32'd0);
			res.power_1b = found[1] ? vals[1] : 32'd0;
			res.power_2a = found[9] ? vals[9] : (found[2] ? vals[2] : 32'd0);
			res.power_2b = found[3] ? vals[3] : 32'd0;
			res.power_3a = found[10] ? vals[10] : (found[4] ? vals[4] : 32'd0);
			res.power_3b = found[5] ? vals[5] : 32'd0;
			res.sample_count = sa[30:0];
			res.rms_mode = rms;
			res.reported_wire = wi;
			res.wire_pulses = (wi != {6'd0, wire_setting} && !rms) ?
				(wire_setting - wi[1:0]) : 2'd0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/ct_frame_parser_crc.sv =====
// The result is registered: an accepted closing byte loads the result register, which drives the output.
// Throughput: one byte per cycle; the byte and result sides are split by the result
// register, and a byte is taken whenever that register is empty or being emptied.
// Reset: arst_n clears the frame state (no tag being parsed), the result valid flag
// and wire_setting.
`default_nettype none
module ct_frame_parser_crc (
	input wire logic clk,
	input wire logic arst_n,
	ctfp_stream_if.sink in_ch,
	ctfp_stream_if.sink cfg_ch,
	ctfp_result_if.source out_ch
);
	logic [1:0] wire_setting_q;
	logic frame_open_q, overflow_q, hex_stop_q, neg_q;
	logic [6:0] byte_count_q;
	logic [15:0] run_crc_q, body_crc_q, rx_crc_q, recent_q;
	logic [2:0] tail_q;
	logic [10:0] found_q;
	logic [3:0] ptag_q;
	logic [1:0] phase_q;
	logic [10:0][31:0] vals_q;
	logic out_valid_q;
	ctfp_pkg::result_t out_q, res_d;

	logic take;
	ctfp_pkg::byte_t b;
	logic is_digit, is_hex, closing;
	logic [3:0] hexv, match_idx;
	logic match_hit;
	logic [31:0] cur, prod, dval;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign b = in_ch.data;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
	assign is_digit = b >= 8'h30 && b <= 8'h39;
	assign closing = frame_open_q && tail_q == 3'd5 && b != ctfp_pkg::ChSlash;

	always_comb begin
		is_hex = 1'b1;
		hexv = 4'd0;
		if (is_digit) begin
			hexv = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			hexv = 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			hexv = 4'(b - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
		match_hit = 1'b0;
		match_idx = 4'd0;
		for (int j = ctfp_pkg::TagCount - 1; j >= 0; j--) begin
			if (ctfp_pkg::tag_code(4'(j)) == recent_q && !found_q[j]) begin
				match_hit = 1'b1;
				match_idx = 4'(j);
			end
		end
		cur = (ptag_q < 4'(ctfp_pkg::TagCount)) ? vals_q[ptag_q] : 32'd0;
		prod = (cur << 3) + (cur << 1);
		dval = {28'd0, b[3:0]};
	end

	ctfp_result_calc u_calc (
		.wire_setting(wire_setting_q),
		.ok(!overflow_q && rx_crc_q == body_crc_q),
		.found(found_q),
		.vals(vals_q),
		.res(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_setting_q <= '0;
		end else if (cfg_ch.valid) begin
			wire_setting_q <= cfg_ch.data[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && closing) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && closing) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			overflow_q <= 1'b0;
			hex_stop_q <= 1'b0;
			neg_q <= 1'b0;
			byte_count_q <= '0;
			run_crc_q <= '0;
			body_crc_q <= '0;
			rx_crc_q <= '0;
			recent_q <= '0;
			tail_q <= '0;
			found_q <= '0;
			ptag_q <= ctfp_pkg::NoTag;
			phase_q <= '0;
			vals_q <= '0;
		end else if (take) begin
			if (b == ctfp_pkg::ChSlash) begin
				frame_open_q <= 1'b1;
				byte_count_q <= 7'd1;
				overflow_q <= 1'b0;
				run_crc_q <= ctfp_pkg::crc_byte(16'd0, ctfp_pkg::ChSlash);
				body_crc_q <= '0;
				tail_q <= '0;
				rx_crc_q <= '0;
				hex_stop_q <= 1'b0;
				recent_q <= {8'd0, ctfp_pkg::ChSlash};
				found_q <= '0;
				ptag_q <= ctfp_pkg::NoTag;
				phase_q <= '0;
				neg_q <= 1'b0;
				vals_q <= '0;
			end else if (frame_open_q) begin
				if (tail_q == 3'd0) begin
					if (byte_count_q >= 7'(ctfp_pkg::MaxFrame)) begin
						overflow_q <= 1'b1;
					end else begin
						byte_count_q <= byte_count_q + 7'd1;
					end
					run_crc_q <= ctfp_pkg::crc_byte(run_crc_q, b);
					if (ptag_q < 4'(ctfp_pkg::TagCount)) begin
						if (phase_q == 2'd0 && (b == ctfp_pkg::ChSpace ||
							(b >= 8'd9 && b <= 8'd13))) begin
							// skip leading white space
						end else if (phase_q == 2'd0 &&
							(b == ctfp_pkg::ChPlus || b == ctfp_pkg::ChMinus)) begin
							neg_q <= b == ctfp_pkg::ChMinus;
							phase_q <= 2'd1;
						end else if (is_digit) begin
							vals_q[ptag_q] <= neg_q ? prod - dval : prod + dval;
							phase_q <= 2'd2;
						end else begin
							ptag_q <= ctfp_pkg::NoTag;
						end
					end
					if (b == ctfp_pkg::ChColon && match_hit) begin
						found_q[match_idx] <= 1'b1;
						vals_q[match_idx] <= '0;
						ptag_q <= match_idx;
						phase_q <= 2'd0;
						neg_q <= 1'b0;
					end
					recent_q <= {recent_q[7:0], b};
					if (b == ctfp_pkg::ChBang) begin
						body_crc_q <= ctfp_pkg::crc_byte(run_crc_q, b);
						tail_q <= 3'd1;
						ptag_q <= ctfp_pkg::NoTag;
					end
				end else if (tail_q < 3'd5) begin
					if (!hex_stop_q && is_hex) begin
						rx_crc_q <= {rx_crc_q[11:0], hexv};
					end else begin
						hex_stop_q <= 1'b1;
					end
					tail_q <= tail_q + 3'd1;
				end else begin
					frame_open_q <= 1'b0;
					tail_q <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/ct_frame_parser_crc_checker.sv =====
module ct_frame_parser_crc_checker
	import ctfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input byte_t in_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_data,
	input logic out_valid,
	input logic out_ready,
	input result_t out_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] TagKey [TagCount] = '{"1A", "1B", "2A", "2B", "3A", "3B",
		"SA", "WI", "1R", "2R", "3R"};

	result_t frame_results[$];
	logic [1:0] wire_cfg;
	logic in_frame;
	int body_len;
	logic too_long;
	logic [15:0] crc_acc;
	logic [15:0] crc_body;
	int tail_pos;
	logic [15:0] crc_rx;
	logic hex_done;
	logic [15:0] last_two;
	logic [TagCount-1:0] seen;
	logic [3:0] cur_tag;
	logic [1:0] num_phase;
	logic num_neg;
	logic [31:0] tag_val [TagCount];

	function automatic logic [15:0] fold_crc(input logic [15:0] crc, input byte_t b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	function automatic int hex_nibble(input byte_t b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "A" && b <= "F") return b - "A" + 10;
		if (b >= "a" && b <= "f") return b - "a" + 10;
		return -1;
	endfunction

	function automatic logic [31:0] pick(input int idx, input int alt);
		if (alt >= 0 && seen[alt]) return tag_val[alt];
		if (seen[idx]) return tag_val[idx];
		return 32'd0;
	endfunction

	task automatic open_frame();
		in_frame = 1'b1;
		body_len = 1;
		too_long = 1'b0;
		crc_acc = fold_crc(16'h0000, ChSlash);
		crc_body = '0;
		tail_pos = 0;
		crc_rx = '0;
		hex_done = 1'b0;
		last_two = {8'h00, ChSlash};
		seen = '0;
		cur_tag = NoTag;
		num_phase = 2'd0;
		num_neg = 1'b0;
		foreach (tag_val[i]) tag_val[i] = '0;
	endtask

	task automatic decode_step(input byte_t b);
		logic [31:0] d;
		if (cur_tag >= TagCount) return;
		if (num_phase == 2'd0) begin
			if (b == ChSpace || (b >= 8'd9 && b <= 8'd13)) return;
			if (b == ChPlus || b == ChMinus) begin
				num_neg = (b == ChMinus);
				num_phase = 2'd1;
				return;
			end
		end
		if (b >= "0" && b <= "9") begin
			d = {24'h0, b - 8'h30};
			tag_val[cur_tag] = num_neg ? tag_val[cur_tag] * 10 - d : tag_val[cur_tag] * 10 + d;
			num_phase = 2'd2;
		end else begin
			cur_tag = NoTag;
		end
	endtask

	task automatic close_frame();
		result_t r;
		logic [31:0] sa;
		logic [7:0] wi;
		r = '0;
		in_frame = 1'b0;
		tail_pos = 0;
		if (!too_long && crc_rx == crc_body) begin
			sa = seen[TagSa] ? tag_val[TagSa] : 32'd0;
			wi = seen[TagWi] ? tag_val[TagWi][7:0] : 8'd0;
			if (sa[31] || sa == 0) sa = 32'd1;
			r.crc_ok = 1'b1;
			r.power_1a = pick(0, 8);
			r.power_1b = pick(1, -1);
			r.power_2a = pick(2, 9);
			r.power_2b = pick(3, -1);
			r.power_3a = pick(4, 10);
			r.power_3b = pick(5, -1);
			r.sample_count = sa[30:0];
			r.rms_mode = seen[Tag3r];
			r.reported_wire = wi;
			r.wire_pulses = (wi != {6'd0, wire_cfg} && !seen[Tag3r]) ? wire_cfg - wi[1:0] : 2'd0;
		end
		frame_results.push_back(r);
	endtask

	task automatic absorb_byte(input byte_t b);
		int h;
		if (b == ChSlash) begin
			open_frame();
			return;
		end
		if (!in_frame) return;
		if (tail_pos == 0) begin
			if (body_len >= MaxFrame) too_long = 1'b1;
			else body_len++;
			crc_acc = fold_crc(crc_acc, b);
			decode_step(b);
			if (b == ChColon) begin
				for (int j = 0; j < TagCount; j++) begin
					if (TagKey[j] == last_two && !seen[j]) begin
						seen[j] = 1'b1;
						tag_val[j] = '0;
						cur_tag = j[3:0];
						num_phase = 2'd0;
						num_neg = 1'b0;
						break;
					end
				end
			end
			last_two = {last_two[7:0], b};
			if (b == ChBang) begin
				crc_body = crc_acc;
				tail_pos = 1;
				cur_tag = NoTag;
			end
		end else if (tail_pos < 5) begin
			h = hex_nibble(b);
			if (!hex_done && h >= 0) crc_rx = {crc_rx[11:0], h[3:0]};
			else hex_done = 1'b1;
			tail_pos++;
		end else begin
			close_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
		if (exp !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			wire_cfg = '0;
			in_frame = 1'b0;
			tail_pos = 0;
			frame_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_results.size() == 0) begin
					$display("%0t: unexpected result, expected none got %0h", $time, out_data);
					errors++;
				end else begin
					e = frame_results.pop_front();
					check_field("crc_ok", e.crc_ok, out_data.crc_ok);
					check_field("power_1a", e.power_1a, out_data.power_1a);
					check_field("power_1b", e.power_1b, out_data.power_1b);
					check_field("power_2a", e.power_2a, out_data.power_2a);
					check_field("power_2b", e.power_2b, out_data.power_2b);
					check_field("power_3a", e.power_3a, out_data.power_3a);
					check_field("power_3b", e.power_3b, out_data.power_3b);
					check_field("sample_count", e.sample_count, out_data.sample_count);
					check_field("rms_mode", e.rms_mode, out_data.rms_mode);
					check_field("reported_wire", e.reported_wire, out_data.reported_wire);
					check_field("wire_pulses", e.wire_pulses, out_data.wire_pulses);
				end
			end
			if (cfg_valid && cfg_ready) wire_cfg = cfg_data;
			if (in_valid && in_ready) absorb_byte(in_data);
			pending = frame_results.size();
		end
	end
endmodule

// ===== tb/ct_frame_parser_crc_tb.sv =====
module ct_frame_parser_crc_tb;
	import ctfp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int idle_pct;
	int stall_pct;
	int sent;
	byte_t frm[$];

	ctfp_stream_if #(8) in_ch();
	ctfp_stream_if #(8) cfg_ch();
	ctfp_result_if out_ch();

	ct_frame_parser_crc dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_ch(cfg_ch),
		.out_ch(out_ch)
	);

	ct_frame_parser_crc_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_data(cfg_ch.data[1:0]),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic put_byte(input byte_t b);
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_queue();
		foreach (frm[i]) put_byte(frm[i]);
		frm.delete();
	endtask

	task automatic write_wire_setting(input logic [1:0] v);
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= {6'd0, v};
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic add_str(input string s);
		foreach (s[i]) frm.push_back(s[i]);
	endtask

	function automatic byte_t hex_char(input logic [3:0] n, input bit lower);
		if (n < 10) return "0" + n;
		return byte_t'((lower ? "a" : "A") + n - 10);
	endfunction

	function automatic byte_t noise_byte();
		byte_t b;
		do b = byte_t'($urandom_range(255)); while (b == ChSlash || b == ChBang);
		return b;
	endfunction

	task automatic seal_frame(input bit corrupt);
		logic [15:0] crc;
		bit lower;
		int bad;
		int start;
		crc = 16'h0000;
		frm.push_back(ChBang);
		start = 0;
		foreach (frm[i]) if (frm[i] == ChSlash) start = i;
		for (int i = start; i < frm.size(); i++) crc = chk.fold_crc(crc, frm[i]);
		lower = 1'($urandom_range(1));
		bad = corrupt ? $urandom_range(3) : -1;
		for (int i = 3; i >= 0; i--) begin
			if (i == bad) frm.push_back(noise_byte());
			else frm.push_back(hex_char(crc[4*i +: 4], lower));
		end
		frm.push_back(noise_byte());
	endtask

	task automatic add_value(input string tag);
		int n;
		add_str(tag);
		frm.push_back(ChColon);
		if ($urandom_range(4) == 0) frm.push_back(($urandom_range(6) == 0) ? ChSpace
			: byte_t'($urandom_range(9, 13)));
		case ($urandom_range(3))
			0: frm.push_back(ChMinus);
			1: frm.push_back(ChPlus);
			default: ;
		endcase
		n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
		repeat (n) frm.push_back(byte_t'("0" + $urandom_range(9)));
		frm.push_back(($urandom_range(3) == 0) ? noise_byte() : ChSpace);
	endtask

	task automatic random_frame();
		string tags [14] = '{"1A", "1B", "2A", "2B", "3A", "3B", "SA", "WI", "1R", "2R",
			"3R", "WI", "SA", "XQ"};
		int kind;
		int cut;
		kind = $urandom_range(99);
		if (kind >= 94) begin
			repeat ($urandom_range(1, 6)) frm.push_back(noise_byte());
			send_queue();
			return;
		end
		frm.push_back(ChSlash);
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(5) == 0) frm.push_back(noise_byte());
			add_value(tags[$urandom_range(13)]);
		end
		if (kind >= 84 && kind < 90)
			while (frm.size() < 100) frm.push_back(noise_byte());
		seal_frame(kind >= 75 && kind < 84);
		if (kind >= 90) begin
			cut = $urandom_range(1, frm.size() - 1);
			while (frm.size() > cut) void'(frm.pop_back());
			if ($urandom_range(1)) frm.push_back(ChSlash);
		end
		send_queue();
	endtask

	initial begin
		int idle_tab [6] = '{0, 78, 0, 30, 0, 78};
		int stall_tab [6] = '{0, 0, 78, 30, 0, 78};
		logic [1:0] wire_tab [6] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd0};
		int target;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		add_str("/1A:2147483647 1B:-2147483648 2A:+5\r\n2B:\t 7 3A:0 3B:99999999999 SA:0 WI:4");
		seal_frame(0);
		add_str("/1R:-1 1A:3 2R:8 3R:12 SA:-3 WI:1 1A:9 2A:4 3A:6");
		seal_frame(0);
		add_str("/SA:x WI:300 1A:");
		frm.push_back(8'h00);
		add_str("5 2B:\v\f-00");
		seal_frame(0);
		send_queue();
		write_wire_setting(2'd3);
		add_str("/WI:2 SA:2147483647 2R:");
		seal_frame(0);
		frm[frm.size() - 1] = ChBang;
		frm[frm.size() - 5] = 8'hFF;
		send_queue();
		frm.push_back(ChSlash);
		while (frm.size() < 95) frm.push_back("1");
		seal_frame(0);
		add_str("/1A:1!12/");
		add_str("/3B:-7");
		seal_frame(0);
		send_queue();

		target = sent;
		for (int p = 0; p < 6; p++) begin
			write_wire_setting(wire_tab[p]);
			idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			target += 130;
			while (sent < target) random_frame();
		end

		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
